/* sv/assert_macros.svh */
// Assertion macros shared by the sphere vertex generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is asserted.
`define UVSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define UVSG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/uvsg_pkg.sv */
// Types, constants and stage functions of the sphere vertex generator pipeline.
`default_nettype none

package uvsg_pkg;

  // Pipeline layout
  localparam int NUM_STG  = 33;
  localparam int DIV_PER  = 3;    // quotient bits per divider stage
  localparam int DIV_LAST = 11;   // stages 1..11 run the dividers
  localparam int P_STG    = 12;
  localparam int X_STG    = 13;
  localparam int X2_STG   = 14;
  localparam int H0_STG   = 15;
  localparam int HSTEPS   = 5;
  localparam int F_STG    = 30;
  localparam int Q_STG    = 31;
  localparam int O_STG    = 32;

  // Sub-steps of one Horner term
  localparam int HSUB_MUL = 0;
  localparam int HSUB_RCP = 1;
  localparam int HSUB_FIX = 2;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  localparam int IN_W  = 16;
  localparam int OUT_W = 176;

  localparam logic [7:0] SEG_RESET  = 8'd32;
  localparam logic [7:0] RING_RESET = 8'd16;
  localparam logic [7:0] MIN_SEGS   = 8'd3;
  localparam logic [7:0] MIN_RINGS  = 8'd2;

  localparam int FRAC_BITS = 15;
  localparam int POS_SH    = 31 - FRAC_BITS;
  localparam int UNIT_SH   = 30 - FRAC_BITS;

  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30 = 30'h2000_0000;

  localparam logic [6:0] SIN_DIV [HSTEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [HSTEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] SIN_RCP [HSTEPS] = '{
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42), 32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6)};
  localparam logic [31:0] COS_RCP [HSTEPS] = '{
    32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)};

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } sm_t;

  typedef struct packed {
    logic [30:0] t;
    logic [29:0] p;
    logic [61:0] pm;
  } lane_t;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
    lane_t       sl;
    lane_t       cl;
    sm_t         s;
    sm_t         c;
  } ang_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [15:0] tangent_x;
    logic [15:0] tangent_z;
  } res_t;

  typedef struct packed {
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic [7:0]  rings;
    logic [7:0]  segs;
    logic        quad_valid;
    logic [7:0]  rem_r;
    logic [7:0]  rem_s;
    logic [33:0] quo_r;
    logic [33:0] quo_s;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [15:0] vnum;
    ang_t        phi;
    ang_t        theta;
    sm_t         nx;
    sm_t         nz;
    res_t        res;
  } stg_t;

  // Clamp counts and indices, start both dividers with the integer bit.
  function automatic stg_t in_fn(logic [7:0] ring_idx, logic [7:0] seg_idx,
                                 logic [7:0] seg_cfg, logic [7:0] ring_cfg);
    stg_t o;
    o = '0;
    o.segs  = (seg_cfg < MIN_SEGS) ? MIN_SEGS : seg_cfg;
    o.rings = (ring_cfg < MIN_RINGS) ? MIN_RINGS : ring_cfg;
    o.ring  = (ring_idx > o.rings) ? o.rings : ring_idx;
    o.seg   = (seg_idx > o.segs) ? o.segs : seg_idx;
    o.quad_valid = (o.ring < o.rings) && (o.seg < o.segs);
    o.quo_s = {33'd0, o.seg == o.segs};
    o.quo_r = {33'd0, o.ring == o.rings};
    o.rem_s = (o.seg == o.segs) ? 8'd0 : o.seg;
    o.rem_r = (o.ring == o.rings) ? 8'd0 : o.ring;
    return o;
  endfunction

  // One restoring step: {quotient bit, new remainder}.
  function automatic logic [8:0] div_one(logic [7:0] rem, logic [7:0] den);
    logic [8:0] r2;
    logic [8:0] d9;
    r2 = {rem, 1'b0};
    d9 = {1'b0, den};
    if (r2 >= d9) begin
      return {1'b1, 8'(r2 - d9)};
    end else begin
      return {1'b0, r2[7:0]};
    end
  endfunction

  function automatic stg_t div_fn(stg_t s);
    stg_t o;
    logic [8:0] bs;
    logic [8:0] br;
    o = s;
    for (int j = 0; j < DIV_PER; j++) begin
      bs = div_one(o.rem_s, o.segs);
      br = div_one(o.rem_r, o.rings);
      o.rem_s = bs[7:0];
      o.rem_r = br[7:0];
      o.quo_s = {o.quo_s[32:0], bs[8]};
      o.quo_r = {o.quo_r[32:0], br[8]};
    end
    return o;
  endfunction

  // Split a phase into quadrant and octant-folded angle (kept in x).
  function automatic ang_t ang_prep(logic [31:0] phase);
    ang_t a;
    logic [29:0] r;
    a = '0;
    r = phase[29:0];
    a.quad = phase[31:30];
    a.swap = r > HALF_Q30;
    a.x    = a.swap ? 30'(ONE_Q30 - {1'b0, r}) : r;
    return a;
  endfunction

  function automatic stg_t prep_fn(stg_t s);
    stg_t o;
    logic [34:0] ps;
    logic [33:0] pr;
    logic [17:0] tu;
    logic [17:0] tv;
    o  = s;
    ps = {1'b0, s.quo_s} + 35'd1;
    pr = {1'b0, s.quo_r[33:1]} + 34'd1;
    tu = {1'b0, s.quo_s[33:17]} + 18'd1;
    tv = {1'b0, s.quo_r[33:17]} + 18'd1;
    o.theta = ang_prep(ps[32:1]);
    o.phi   = ang_prep(pr[32:1]);
    o.tex_u = tu[16:1];
    o.tex_v = tv[16:1];
    o.vnum  = 16'({8'd0, s.ring} * ({8'd0, s.segs} + 16'd1) + {8'd0, s.seg});
    return o;
  endfunction

  function automatic logic [29:0] x_of(logic [29:0] a);
    logic [61:0] pr;
    pr = 62'(a) * 62'(PI_Q30) + (62'd1 << 30);
    return pr[60:31];
  endfunction

  function automatic stg_t x_fn(stg_t s);
    stg_t o;
    o = s;
    o.phi.x   = x_of(s.phi.x);
    o.theta.x = x_of(s.theta.x);
    return o;
  endfunction

  function automatic ang_t x2_of(ang_t a);
    ang_t o;
    logic [60:0] pr;
    o = a;
    pr = 61'(a.x) * 61'(a.x) + 61'(HALF_Q30);
    o.x2   = pr[59:30];
    o.sl.t = ONE_Q30;
    o.cl.t = ONE_Q30;
    return o;
  endfunction

  function automatic stg_t x2_fn(stg_t s);
    stg_t o;
    o = s;
    o.phi   = x2_of(s.phi);
    o.theta = x2_of(s.theta);
    return o;
  endfunction

  // t = 1 - round(x2*t) / div, the divide done by reciprocal and one fix-up.
  function automatic lane_t lane_fn(lane_t l, logic [29:0] x2, logic [6:0] dv,
                                    logic [31:0] rc, int sub);
    lane_t o;
    logic [60:0] pr;
    logic [29:0] q0;
    logic [36:0] qd;
    logic [29:0] rm;
    logic [29:0] q;
    o  = l;
    pr = '0;
    q0 = '0;
    qd = '0;
    rm = '0;
    q  = '0;
    case (sub)
      HSUB_MUL: begin
        pr  = 61'(x2) * 61'(l.t) + 61'(HALF_Q30);
        o.p = pr[59:30];
      end
      HSUB_RCP: begin
        o.pm = 62'(l.p) * 62'(rc);
      end
      HSUB_FIX: begin
        q0  = l.pm[61:32];
        qd  = 37'(q0) * 37'(dv);
        rm  = 30'(37'(l.p) - qd);
        q   = q0 + 30'(rm >= 30'(dv));
        o.t = ONE_Q30 - 31'(q);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic ang_t horner_ang(ang_t a, int step, int sub);
    ang_t o;
    o = a;
    o.sl = lane_fn(a.sl, a.x2, SIN_DIV[3'(step)], SIN_RCP[3'(step)], sub);
    o.cl = lane_fn(a.cl, a.x2, COS_DIV[3'(step)], COS_RCP[3'(step)], sub);
    return o;
  endfunction

  function automatic stg_t horner_fn(stg_t s, int step, int sub);
    stg_t o;
    o = s;
    o.phi   = horner_ang(s.phi, step, sub);
    o.theta = horner_ang(s.theta, step, sub);
    return o;
  endfunction

  // Finish sine, undo the octant fold and apply quadrant signs.
  function automatic ang_t ang_fin(ang_t a);
    ang_t o;
    logic [60:0] pr;
    logic [30:0] sn;
    logic [30:0] cs;
    o  = a;
    pr = 61'(a.x) * 61'(a.sl.t) + 61'(HALF_Q30);
    sn = a.swap ? a.cl.t : pr[60:30];
    cs = a.swap ? pr[60:30] : a.cl.t;
    case (a.quad)
      QUAD_I: begin
        o.s = '{neg: 1'b0, mag: sn};
        o.c = '{neg: 1'b0, mag: cs};
      end
      QUAD_II: begin
        o.s = '{neg: 1'b0, mag: cs};
        o.c = '{neg: 1'b1, mag: sn};
      end
      QUAD_III: begin
        o.s = '{neg: 1'b1, mag: sn};
        o.c = '{neg: 1'b1, mag: cs};
      end
      default: begin
        o.s = '{neg: 1'b1, mag: cs};
        o.c = '{neg: 1'b0, mag: sn};
      end
    endcase
    return o;
  endfunction

  function automatic stg_t f_fn(stg_t s);
    stg_t o;
    o = s;
    o.phi   = ang_fin(s.phi);
    o.theta = ang_fin(s.theta);
    return o;
  endfunction

  function automatic sm_t qmul(sm_t a, sm_t b);
    sm_t o;
    logic [61:0] pr;
    pr    = 62'(a.mag) * 62'(b.mag) + 62'(HALF_Q30);
    o.neg = a.neg ^ b.neg;
    o.mag = pr[60:30];
    return o;
  endfunction

  function automatic stg_t q_fn(stg_t s);
    stg_t o;
    o = s;
    o.nx = qmul(s.phi.s, s.theta.c);
    o.nz = qmul(s.phi.s, s.theta.s);
    return o;
  endfunction

  // Round half away from zero, then saturate to 16 bits.
  function automatic logic [15:0] to_out(sm_t v, int sh);
    logic [31:0] sum;
    logic [31:0] m;
    sum = 32'(v.mag) + (32'd1 << (sh - 1));
    m   = sum >> sh;
    if (!v.neg) begin
      return (m > 32'd32767) ? 16'h7FFF : m[15:0];
    end else begin
      return (m > 32'd32768) ? 16'h8000 : 16'(~m[15:0] + 16'd1);
    end
  endfunction

  function automatic stg_t o_fn(stg_t s);
    stg_t o;
    sm_t  nst;
    o   = s;
    nst = '{neg: ~s.theta.s.neg, mag: s.theta.s.mag};
    o.res.pos_x     = to_out(s.nx, POS_SH);
    o.res.pos_y     = to_out(s.phi.c, POS_SH);
    o.res.pos_z     = to_out(s.nz, POS_SH);
    o.res.normal_x  = to_out(s.nx, UNIT_SH);
    o.res.normal_y  = to_out(s.phi.c, UNIT_SH);
    o.res.normal_z  = to_out(s.nz, UNIT_SH);
    o.res.tangent_x = to_out(nst, UNIT_SH);
    o.res.tangent_z = to_out(s.theta.c, UNIT_SH);
    return o;
  endfunction

endpackage

`default_nettype wire

/* sv/uv_sphere_vertex_generator.sv */
// Top level of the UV sphere vertex generator: config registers and vertex pipeline.
//
//   channel   dir   handshake                 payload
//   in_*      in    in_tvalid / in_tready     ring_index, segment_index
//   out_*     out   out_tvalid / out_tready   vertex attributes, quad_valid in tuser
//   APB       in    psel/penable/pready       segment_count @0x0, ring_count @0x4
//
// One vertex per cycle while the output is not stalled; the pipeline holds the 11 divider stages
// (3 quotient bits each) and the 15 stages of the sine/cosine series.
// Reset is synchronous: it clears all stage valid bits and loads 32/16 counts.
// Each stage holds while the one after it is full and stalled; bubbles close up, so the
// input keeps taking requests until every stage holds a stalled vertex.
`default_nettype none

module uv_sphere_vertex_generator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [uvsg_pkg::IN_W-1:0]    in_tdata,   // ring_index, segment_index
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
  // tangent_x, tangent_z, vertex_number
  output logic [uvsg_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tuser,  // quad_valid
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  `include "assert_macros.svh"

  typedef enum logic {
    REG_SEGMENT_COUNT = 1'b0,
    REG_RING_COUNT    = 1'b1
  } reg_sel_t;

  localparam int LAST = uvsg_pkg::NUM_STG - 1;

  logic [7:0] seg_cnt_r;
  logic [7:0] ring_cnt_r;
  reg_sel_t   reg_sel;
  logic       cfg_wr;

  logic [uvsg_pkg::NUM_STG-1:0] vld_r;
  logic [uvsg_pkg::NUM_STG-1:0] vld_nxt;
  logic [uvsg_pkg::NUM_STG-1:0] rdy;
  uvsg_pkg::stg_t               pipe_r   [uvsg_pkg::NUM_STG];
  uvsg_pkg::stg_t               pipe_nxt [uvsg_pkg::NUM_STG];

  // Configuration
  assign reg_sel = reg_sel_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r  <= uvsg_pkg::SEG_RESET;
      ring_cnt_r <= uvsg_pkg::RING_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SEGMENT_COUNT: seg_cnt_r  <= pwdata[7:0];
        REG_RING_COUNT:    ring_cnt_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SEGMENT_COUNT: prdata = {24'd0, seg_cnt_r};
      REG_RING_COUNT:    prdata = {24'd0, ring_cnt_r};
      default:           prdata = '0;
    endcase
  end

  // Stage handshake: a stage takes new data when empty or when its
  // contents move on.
  assign rdy[LAST] = ~vld_r[LAST] | out_tready;
  for (genvar k = 0; k < LAST; k++) begin : g_rdy
    assign rdy[k] = ~vld_r[k] | rdy[k+1];
  end
  assign in_tready = rdy[0];

  assign pipe_nxt[0] = uvsg_pkg::in_fn(in_tdata[7:0], in_tdata[15:8], seg_cnt_r, ring_cnt_r);
  assign vld_nxt[0]  = rdy[0] ? in_tvalid : vld_r[0];

  for (genvar k = 1; k < uvsg_pkg::NUM_STG; k++) begin : g_stg
    assign vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    if (k <= uvsg_pkg::DIV_LAST) begin : g_div
      assign pipe_nxt[k] = uvsg_pkg::div_fn(pipe_r[k-1]);
    end else if (k == uvsg_pkg::P_STG) begin : g_prep
      assign pipe_nxt[k] = uvsg_pkg::prep_fn(pipe_r[k-1]);
    end else if (k == uvsg_pkg::X_STG) begin : g_x
      assign pipe_nxt[k] = uvsg_pkg::x_fn(pipe_r[k-1]);
    end else if (k == uvsg_pkg::X2_STG) begin : g_x2
      assign pipe_nxt[k] = uvsg_pkg::x2_fn(pipe_r[k-1]);
    end else if (k < uvsg_pkg::F_STG) begin : g_hrn
      localparam int HSTEP = (k - uvsg_pkg::H0_STG) / 3;
      localparam int HSUB  = (k - uvsg_pkg::H0_STG) % 3;
      assign pipe_nxt[k] = uvsg_pkg::horner_fn(pipe_r[k-1], HSTEP, HSUB);
    end else if (k == uvsg_pkg::F_STG) begin : g_fin
      assign pipe_nxt[k] = uvsg_pkg::f_fn(pipe_r[k-1]);
    end else if (k == uvsg_pkg::Q_STG) begin : g_qmul
      assign pipe_nxt[k] = uvsg_pkg::q_fn(pipe_r[k-1]);
    end else begin : g_out
      assign pipe_nxt[k] = uvsg_pkg::o_fn(pipe_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < uvsg_pkg::NUM_STG; k++) begin
      if (rdy[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tuser  = pipe_r[LAST].quad_valid;
  assign out_tdata  = {pipe_r[LAST].vnum,
                       pipe_r[LAST].res.tangent_z, pipe_r[LAST].res.tangent_x,
                       pipe_r[LAST].tex_v, pipe_r[LAST].tex_u,
                       pipe_r[LAST].res.normal_z, pipe_r[LAST].res.normal_y,
                       pipe_r[LAST].res.normal_x,
                       pipe_r[LAST].res.pos_z, pipe_r[LAST].res.pos_y,
                       pipe_r[LAST].res.pos_x};

  // Segment zero sits at angle zero: tangent points along +z exactly.
  `UVSG_ASSERT(a_seam_tangent, vld_r[LAST] && pipe_r[LAST].seg == 8'd0 |-> pipe_r[LAST].res.tangent_z == 16'h7FFF && pipe_r[LAST].res.tangent_x == 16'h0000, "tangent at segment zero is not +z")
  // Last column of the grid maps to u = 1.0.
  `UVSG_ASSERT(a_tex_edge, vld_r[LAST] && pipe_r[LAST].seg == pipe_r[LAST].segs |-> pipe_r[LAST].tex_u == 16'h8000, "u at last segment is not 1.0")
  // Inner quads never reach the texture edge.
  `UVSG_ASSERT(a_quad_tex, vld_r[LAST] && pipe_r[LAST].quad_valid |-> pipe_r[LAST].tex_u < 16'h8000 && pipe_r[LAST].tex_v < 16'h8000, "quad flagged at texture edge")
  // Input backpressure only when the first two stages are both full.
  `UVSG_ASSERT_ALWAYS(a_in_stall, !in_tready |-> vld_r[0] && vld_r[1], "input stalled with room in pipeline")

endmodule

`default_nettype wire
